### rtl/hsl_lightness_adjust_macros.svh
// Assertion macros used by the checker file.
`ifndef HSL_LIGHTNESS_ADJUST_MACROS_SVH
`define HSL_LIGHTNESS_ADJUST_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define HLA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hla: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define HLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hla: next-cycle check failed");

`endif

### rtl/hla_pkg.sv
// ----------------------------------------------------------------------------
// hla_pkg
// Types and constants of the HSL lightness adjust pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package hla_pkg;

   localparam int AMT_FRAC = 14;
   localparam logic signed [15:0] AMT_ONE = 16'sd16384;
   localparam logic [21:0] LIGHT_MID = 22'd4177920;   // 255 * 2^14
   localparam int STAGES_FRONT = 3;
   localparam int STAGES_MULT = 2;
   localparam int STAGES_DIV = 9;
   localparam int STAGES = STAGES_FRONT + STAGES_MULT + STAGES_DIV;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } hla_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } hla_rsp_type;

   // Front end to multiplier stages
   typedef struct packed {
      logic [22:0]      p;
      logic [7:0]       k;
      logic [21:0]      k2;
      logic [7:0]       d;
      logic [2:0][7:0]  diff;
      logic             gray;
   } hla_front_type;

   // Multiplier stages to divider
   typedef struct packed {
      logic [2:0][17:0] n;
      logic [7:0]       dv;
   } hla_num_type;

endpackage
`default_nettype wire

### rtl/hla_front.sv
// ----------------------------------------------------------------------------
// hla_front
// Min/max, new doubled lightness and chroma spans (three stages).
// ----------------------------------------------------------------------------
`default_nettype none
module hla_front
   import hla_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [STAGES_FRONT-1:0]  ld,
   input  wire hla_req_type              req_data,
   input  wire logic signed [15:0]       amount,
   output hla_front_type                 front
);

   logic [2:0][7:0]     ch;
   logic [7:0]          mx, mn;
   logic signed [15:0]  a_clamp;

   logic [2:0][7:0]     ch0_ff;
   logic [7:0]          mn0_ff;
   logic [8:0]          s0_ff;
   logic [7:0]          d0_ff;
   logic signed [15:0]  a0_ff;

   logic [8:0]          mul_x;
   logic [14:0]         mul_y;
   logic [22:0]         p_in;
   logic [22:0]         p1_ff;
   logic [8:0]          s1_ff;
   logic [7:0]          d1_ff;
   logic [2:0][7:0]     diff1_ff;

   hla_front_type       front_in;
   hla_front_type       front_ff;

   assign ch = {req_data.in_red, req_data.in_green, req_data.in_blue};

   always_comb begin
      mx = ch[2];
      mn = ch[2];
      if (ch[1] > mx) mx = ch[1];
      if (ch[0] > mx) mx = ch[0];
      if (ch[1] < mn) mn = ch[1];
      if (ch[0] < mn) mn = ch[0];
      if (amount > AMT_ONE) begin
         a_clamp = AMT_ONE;
      end else if (amount < -AMT_ONE) begin
         a_clamp = -AMT_ONE;
      end else begin
         a_clamp = amount;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ch0_ff <= ch;
         mn0_ff <= mn;
         s0_ff  <= {1'b0, mx} + {1'b0, mn};
         d0_ff  <= mx - mn;
         a0_ff  <= a_clamp;
      end
   end

   // Raise toward white or lower toward black with one shared multiplier
   always_comb begin
      if (!a0_ff[15]) begin
         mul_x = 9'd510 - s0_ff;
         mul_y = a0_ff[14:0];
         p_in  = {s0_ff, 14'd0} + 23'(mul_x * mul_y);
      end else begin
         mul_x = s0_ff;
         mul_y = 15'(AMT_ONE + a0_ff);
         p_in  = 23'(mul_x * mul_y);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         p1_ff <= p_in;
         s1_ff <= s0_ff;
         d1_ff <= d0_ff;
         for (int i = 0; i < 3; i++) begin
            diff1_ff[i] <= ch0_ff[i] - mn0_ff;
         end
      end
   end

   always_comb begin
      front_in.p    = p1_ff;
      front_in.k    = (s1_ff >= 9'd255) ? 8'(9'd510 - s1_ff) : s1_ff[7:0];
      front_in.k2   = ({1'b0, p1_ff} >= {2'b0, LIGHT_MID}) ?
                      22'({LIGHT_MID, 1'b0} - {1'b0, p1_ff}) : p1_ff[21:0];
      front_in.d    = d1_ff;
      front_in.diff = diff1_ff;
      front_in.gray = (d1_ff == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule
`default_nettype wire

### rtl/hla_mult.sv
// ----------------------------------------------------------------------------
// hla_mult
// Channel numerators and prescaled dividends (two stages).
// ----------------------------------------------------------------------------
`default_nettype none
module hla_mult
   import hla_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [STAGES_MULT-1:0]  ld,
   input  wire hla_front_type           front,
   output hla_num_type                  num
);

   logic [30:0]       pk_ff;
   logic [29:0]       kd_ff;
   logic [2:0][29:0]  m_ff;
   logic [7:0]        k_ff;
   logic [22:0]       p_ff;
   logic              gray_ff;

   logic signed [34:0] sum   [3];
   logic signed [34:0] rnd   [3];
   logic [23:0]        gsum;
   hla_num_type        num_in;
   hla_num_type        num_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         pk_ff   <= 31'(front.p * front.k);
         kd_ff   <= 30'(front.k2 * front.d);
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= 30'(front.k2 * front.diff[i]);
         end
         k_ff    <= front.k;
         p_ff    <= front.p;
         gray_ff <= front.gray;
      end
   end

   // Add half the divisor, drop the 2^15 factor; the rest divides by k
   always_comb begin
      gsum = {1'b0, p_ff} + 24'd16384;
      for (int i = 0; i < 3; i++) begin
         sum[i] = $signed({4'd0, pk_ff}) - $signed({5'd0, kd_ff})
                + $signed({4'd0, m_ff[i], 1'b0});
         rnd[i] = sum[i] + $signed({13'd0, k_ff, 14'd0});
         if (gray_ff) begin
            num_in.n[i] = {9'd0, gsum[23:15]};
         end else if (sum[i] < 0) begin
            num_in.n[i] = 18'd0;
         end else begin
            num_in.n[i] = rnd[i][32:15];
         end
      end
      num_in.dv = gray_ff ? 8'd1 : k_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         num_ff <= num_in;
      end
   end

   assign num = num_ff;

endmodule
`default_nettype wire

### rtl/hla_div.sv
// ----------------------------------------------------------------------------
// hla_div
// Pipelined restoring divide by the 8-bit divisor dv, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module hla_div
   import hla_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [STAGES_DIV-1:0]  ld,
   input  wire hla_num_type            num,
   output hla_rsp_type                 rsp
);

   localparam int STEPS = STAGES_DIV - 1;

   logic [2:0][17:0] rem_ff [STAGES_DIV];
   logic [2:0][7:0]  q_ff   [STAGES_DIV];
   logic [2:0]       sat_ff [STAGES_DIV];
   logic [7:0]       dv_ff  [STAGES_DIV];

   // Saturation check first: quotient of 256 or more clamps to 255
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= num.n[i];
            q_ff[0][i]   <= 8'd0;
            sat_ff[0][i] <= (num.n[i] >= {2'd0, num.dv, 8'd0});
         end
         dv_ff[0] <= num.dv;
      end
   end

   for (genvar s = 1; s < STAGES_DIV; s++) begin : g_step
      localparam int BIT = STEPS - s;
      logic [17:0] trial;
      assign trial = 18'(dv_ff[s-1]) << BIT;

      always_ff @(posedge clock) begin
         if (ld[s]) begin
            for (int i = 0; i < 3; i++) begin
               if (!sat_ff[s-1][i] && rem_ff[s-1][i] >= trial) begin
                  rem_ff[s][i] <= rem_ff[s-1][i] - trial;
                  q_ff[s][i]   <= q_ff[s-1][i] | (8'd1 << BIT);
               end else begin
                  rem_ff[s][i] <= rem_ff[s-1][i];
                  q_ff[s][i]   <= q_ff[s-1][i];
               end
            end
            sat_ff[s] <= sat_ff[s-1];
            dv_ff[s]  <= dv_ff[s-1];
         end
      end
   end

   assign rsp.out_red   = sat_ff[STEPS][2] ? 8'hFF : q_ff[STEPS][2];
   assign rsp.out_green = sat_ff[STEPS][1] ? 8'hFF : q_ff[STEPS][1];
   assign rsp.out_blue  = sat_ff[STEPS][0] ? 8'hFF : q_ff[STEPS][0];

endmodule
`default_nettype wire

### rtl/hsl_lightness_adjust.sv
// ----------------------------------------------------------------------------
// hsl_lightness_adjust
// HSL lightness adjustment of an 8-bit RGB pixel stream.
// ----------------------------------------------------------------------------
// Each request is one RGB pixel. The pixel's lightness moves toward white
// (positive csr amount) or black (negative) by amount * 2^-14, clamped to
// +-1.0, with hue and saturation kept; each channel comes back rounded half
// away from zero and saturated to 0..255. The pipeline is 14 register stages
// deep: three for min/max, lightness and chroma spans, two for the channel
// products, and nine for a restoring divide by the lightness divisor k (a
// saturation check, then one quotient bit per stage for eight bits). One
// pixel enters every cycle while req_stall is low, so throughput is one pixel
// per clock without output stalls. A stall holds only the stages that are
// full, so bubbles close up before the input side stalls. Write the amount
// register only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module hsl_lightness_adjust
   import hla_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire hla_req_type  req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output hla_rsp_type       rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);

   logic signed [15:0] amount_ff;
   logic [STAGES-1:0]  valid_ff;
   logic [STAGES-1:0]  valid_in;
   logic [STAGES-1:0]  ld;
   hla_front_type      front;
   hla_num_type        num;

   // Lightness amount register, raw; clamping happens in the first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= '0;
      end else if (csr_wr_en) begin
         amount_ff <= $signed(csr_wr_data);
      end
   end

   // A stage loads when it is empty or when the stage after it moves on
   always_comb begin
      ld[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ld[i] = !valid_ff[i] || ld[i+1];
      end
      valid_in = valid_ff;
      if (ld[0]) valid_in[0] = req_valid;
      for (int i = 1; i < STAGES; i++) begin
         if (ld[i]) valid_in[i] = valid_ff[i-1];
      end
   end

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ld[0];
   assign rsp_valid = valid_ff[STAGES-1];

   hla_front u_front (
      .clock    (clock),
      .ld       (ld[STAGES_FRONT-1:0]),
      .req_data (req_data),
      .amount   (amount_ff),
      .front    (front)
   );

   hla_mult u_mult (
      .clock (clock),
      .ld    (ld[STAGES_FRONT+STAGES_MULT-1:STAGES_FRONT]),
      .front (front),
      .num   (num)
   );

   hla_div u_div (
      .clock (clock),
      .ld    (ld[STAGES-1:STAGES_FRONT+STAGES_MULT]),
      .num   (num),
      .rsp   (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/hla_checker.sv
// ----------------------------------------------------------------------------
// hla_port_checker
// Port-level checks of the lightness adjust pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsl_lightness_adjust_macros.svh"
module hla_port_checker
   import hla_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire hla_rsp_type  rsp_data
);

   // Reset empties the pipeline
   `HLA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // The input side stalls only behind a held result
   `HLA_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_valid || !rsp_stall, !req_stall)
   // A held result stays put
   `HLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data))

endmodule

bind hsl_lightness_adjust hla_port_checker u_hla_checker (.*);
`default_nettype wire
